// File: rtl/core/cascaded_biquad_stereo_filter_core_defines.svh
// assertion macros shared by the core
`ifndef CASCADED_BIQUAD_STEREO_FILTER_CORE_DEFINES_SVH
`define CASCADED_BIQUAD_STEREO_FILTER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CBQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbq check failed");

// consequent must hold in the cycle after the antecedent
`define CBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbq check failed");

`endif

// File: rtl/core/cbq_pkg.sv
package cbq_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_SHIFT = 8;
  localparam int PRE_GAIN_W = 10;
  localparam int VOLUME_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int TERM_W     = 3;

  // defaults for the top level parameters
  localparam int FRAC_BITS_DEF    = 16;
  localparam int NUM_STAGES_DEF   = 2;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 16;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd6;

  localparam logic [PRE_GAIN_W-1:0] PRE_GAIN_RST = 10'd0;
  localparam logic [VOLUME_W-1:0]   VOLUME_RST   = 8'd255;

  // product order within one biquad stage
  localparam logic [TERM_W-1:0] TERM_B0 = 3'd0;
  localparam logic [TERM_W-1:0] TERM_B1 = 3'd1;
  localparam logic [TERM_W-1:0] TERM_B2 = 3'd2;
  localparam logic [TERM_W-1:0] TERM_A1 = 3'd3;
  localparam logic [TERM_W-1:0] TERM_A2 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_MUL,
    ST_PRE_ACC,
    ST_READ,
    ST_MAC,
    ST_MAC_LAST,
    ST_WRITE,
    ST_VOL_MUL,
    ST_VOL_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    OPS_PRE,
    OPS_TERM,
    OPS_VOL
  } op_sel_e;

  typedef struct packed {
    logic              mul_en;
    acc_op_e           acc_op;
    logic              gain_sel;
    op_sel_e           op_sel;
    logic [TERM_W-1:0] term;
    logic              rd_en;
    logic              wr_en;
    logic              x_load;
    logic              out_load;
  } ctrl_t;

  // per channel and stage history row
  typedef struct packed {
    logic [DATA_W-1:0] x1;
    logic [DATA_W-1:0] x2;
    logic [DATA_W-1:0] y1;
    logic [DATA_W-1:0] y2;
  } row_t;

endpackage

// File: rtl/core/cbq_in_if.sv
interface cbq_in_if #(
  parameter int SAMPLE_BITS = cbq_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink (input valid, input sample_in, input channel, output ready);
endinterface

// File: rtl/core/cbq_out_if.sv
interface cbq_out_if ();
  logic                            valid;
  logic                            ready;
  logic signed [cbq_pkg::DATA_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/cascaded_biquad_stereo_filter_core.sv
// items are taken one at a time: ready is low from acceptance until the result enters the
//   output register, which waits while an earlier result is still held; the single
//   32x32 multiplier computes the pre-gain, five products per stage and the volume
// reset (async, active low): idle, ready high, output empty, coefficients zero,
//   pre-gain zero, volume 255, all filter histories read as zero
`include "cascaded_biquad_stereo_filter_core_defines.svh"

module cascaded_biquad_stereo_filter_core #(
  parameter int FRAC_BITS    = cbq_pkg::FRAC_BITS_DEF,
  parameter int NUM_STAGES   = cbq_pkg::NUM_STAGES_DEF,
  parameter int NUM_CHANNELS = cbq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = cbq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbq_in_if.sink                        in_i,
  cbq_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cbq_pkg::DATA_W-1:0]    cfg_wdata_i
);

  localparam int DW     = cbq_pkg::DATA_W;
  localparam int ROWS   = NUM_CHANNELS * NUM_STAGES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ST_W   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  // configuration registers
  logic signed [DW-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic [cbq_pkg::PRE_GAIN_W-1:0] pre_gain_q;
  logic [cbq_pkg::VOLUME_W-1:0]   volume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q  <= '0;
      coef_b1_q  <= '0;
      coef_b2_q  <= '0;
      coef_a1_q  <= '0;
      coef_a2_q  <= '0;
      pre_gain_q <= cbq_pkg::PRE_GAIN_RST;
      volume_q   <= cbq_pkg::VOLUME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbq_pkg::REG_COEF_B0:  coef_b0_q  <= cfg_wdata_i;
        cbq_pkg::REG_COEF_B1:  coef_b1_q  <= cfg_wdata_i;
        cbq_pkg::REG_COEF_B2:  coef_b2_q  <= cfg_wdata_i;
        cbq_pkg::REG_COEF_A1:  coef_a1_q  <= cfg_wdata_i;
        cbq_pkg::REG_COEF_A2:  coef_a2_q  <= cfg_wdata_i;
        cbq_pkg::REG_PRE_GAIN: pre_gain_q <= cfg_wdata_i[cbq_pkg::PRE_GAIN_W-1:0];
        cbq_pkg::REG_VOLUME:   volume_q   <= cfg_wdata_i[cbq_pkg::VOLUME_W-1:0];
        default:               ; // unmapped index, write dropped
      endcase
    end
  end

  // sequencer
  cbq_pkg::ctrl_t  ctrl;
  logic [ST_W-1:0] stage;
  logic            in_fire;
  logic            out_free;
  logic            out_valid_q;
  logic [DW-1:0]   out_data_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  cbq_seq #(
    .NUM_STAGES (NUM_STAGES),
    .ST_W       (ST_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .in_ready_o (in_i.ready),
    .stage_o    (stage),
    .ctrl_o     (ctrl)
  );

  // captured item: sign-extended sample and clamped channel
  logic signed [DW-1:0] sample_q;
  logic                 ch_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= {{(DW-SAMPLE_BITS){in_i.sample_in[SAMPLE_BITS-1]}}, in_i.sample_in};
      // with a single channel, every item maps onto channel zero
      ch_q     <= (NUM_CHANNELS > 1) ? in_i.channel : 1'b0;
    end
  end

  // stage input x, taken from the accumulator before each stage
  logic signed [DW-1:0] acc;
  logic signed [DW-1:0] x_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.x_load) begin
      x_q <= acc;
    end
  end

  // history rows, one per channel and stage
  logic [ROW_AW-1:0] row_addr;
  cbq_pkg::row_t     rd_row;
  cbq_pkg::row_t     wr_row;

  assign row_addr = ROW_AW'(int'(ch_q) * NUM_STAGES + int'(stage));

  // shift the delay line: new x and y enter, oldest entries drop out
  always_comb begin
    wr_row.x1 = x_q;
    wr_row.x2 = rd_row.x1;
    wr_row.y1 = acc;
    wr_row.y2 = rd_row.y1;
  end

  cbq_hist_mem #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ctrl.rd_en),
    .rd_addr_i (row_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (ctrl.wr_en),
    .wr_addr_i (row_addr),
    .wr_row_i  (wr_row)
  );

  // operand selection for the shared multiplier
  logic signed [DW-1:0] op_a, op_b;

  always_comb begin
    op_a = coef_b0_q;
    op_b = x_q;
    case (ctrl.op_sel)
      cbq_pkg::OPS_PRE: begin
        op_a = {{(DW-cbq_pkg::PRE_GAIN_W){1'b0}}, pre_gain_q};
        op_b = sample_q;
      end
      cbq_pkg::OPS_VOL: begin
        op_a = {{(DW-cbq_pkg::VOLUME_W){1'b0}}, volume_q};
        op_b = acc;
      end
      default: begin
        case (ctrl.term)
          cbq_pkg::TERM_B0: begin
            op_a = coef_b0_q;
            op_b = x_q;
          end
          cbq_pkg::TERM_B1: begin
            op_a = coef_b1_q;
            op_b = rd_row.x1;
          end
          cbq_pkg::TERM_B2: begin
            op_a = coef_b2_q;
            op_b = rd_row.x2;
          end
          cbq_pkg::TERM_A1: begin
            op_a = coef_a1_q;
            op_b = rd_row.y1;
          end
          default: begin
            op_a = coef_a2_q;
            op_b = rd_row.y2;
          end
        endcase
      end
    endcase
  end

  // multiplier plus accumulator; also holds the gain-scaled values
  cbq_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  // output register, frees the core while the result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= acc;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // an accepted item keeps the core busy on the next cycle
  `CBQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_i.ready)
  // the stage counter stays within the cascade
  `CBQ_ASSERT_NOW(a_stage_range, clk_i, rst_ni, 1'b1, int'(stage) < NUM_STAGES)
  // a new result never overwrites one that was not taken
  `CBQ_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, ctrl.out_load, !out_valid_q || out_o.ready)

endmodule

// File: rtl/core/cbq_mac.sv
module cbq_mac #(
  parameter int FRAC_BITS = cbq_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  cbq_pkg::ctrl_t                     ctrl_i,
  input  logic signed [cbq_pkg::DATA_W-1:0]  op_a_i,
  input  logic signed [cbq_pkg::DATA_W-1:0]  op_b_i,
  output logic signed [cbq_pkg::DATA_W-1:0]  acc_o
);

  logic signed [2*cbq_pkg::DATA_W-1:0] prod;
  logic signed [2*cbq_pkg::DATA_W-1:0] prod_q;
  logic signed [cbq_pkg::DATA_W-1:0]   lo_word;
  logic signed [cbq_pkg::DATA_W-1:0]   term;
  logic signed [cbq_pkg::DATA_W-1:0]   acc_d, acc_q;

  assign prod = op_a_i * op_b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod;
    end
  end

  // gain product wraps to 32 bits before the shift, coefficient product does not
  assign lo_word = prod_q[cbq_pkg::DATA_W-1:0];

  always_comb begin
    if (ctrl_i.gain_sel) begin
      term = lo_word >>> cbq_pkg::GAIN_SHIFT;
    end else begin
      term = prod_q[FRAC_BITS+cbq_pkg::DATA_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    case (ctrl_i.acc_op)
      cbq_pkg::ACC_LOAD: acc_d = term;
      cbq_pkg::ACC_ADD:  acc_d = acc_q + term;
      cbq_pkg::ACC_SUB:  acc_d = acc_q - term;
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/cbq_hist_mem.sv
module cbq_hist_mem #(
  parameter int ROWS   = 4,
  parameter int ROW_AW = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ROW_AW-1:0] rd_addr_i,
  output cbq_pkg::row_t     rd_row_o,
  input  logic              wr_en_i,
  input  logic [ROW_AW-1:0] wr_addr_i,
  input  cbq_pkg::row_t     wr_row_i
);

  cbq_pkg::row_t mem [ROWS];
  cbq_pkg::row_t rd_q;
  logic [ROWS-1:0] vld_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // rows never written read as zero history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/core/cbq_seq.sv
module cbq_seq #(
  parameter int NUM_STAGES = cbq_pkg::NUM_STAGES_DEF,
  parameter int ST_W       = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output logic [ST_W-1:0] stage_o,
  output cbq_pkg::ctrl_t  ctrl_o
);

  cbq_pkg::state_e             state_d, state_q;
  logic [cbq_pkg::TERM_W-1:0]  term_d, term_q;
  logic [ST_W-1:0]             stage_d, stage_q;
  logic                        last_stage;

  assign last_stage = (stage_q == ST_W'(NUM_STAGES - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbq_pkg::ST_IDLE:     if (in_fire_i) state_d = cbq_pkg::ST_PRE_MUL;
      cbq_pkg::ST_PRE_MUL:  state_d = cbq_pkg::ST_PRE_ACC;
      cbq_pkg::ST_PRE_ACC:  state_d = cbq_pkg::ST_READ;
      cbq_pkg::ST_READ:     state_d = cbq_pkg::ST_MAC;
      cbq_pkg::ST_MAC:      if (term_q == cbq_pkg::TERM_A2) state_d = cbq_pkg::ST_MAC_LAST;
      cbq_pkg::ST_MAC_LAST: state_d = cbq_pkg::ST_WRITE;
      cbq_pkg::ST_WRITE:    state_d = last_stage ? cbq_pkg::ST_VOL_MUL : cbq_pkg::ST_READ;
      cbq_pkg::ST_VOL_MUL:  state_d = cbq_pkg::ST_VOL_ACC;
      cbq_pkg::ST_VOL_ACC:  state_d = cbq_pkg::ST_DONE;
      cbq_pkg::ST_DONE:     if (out_free_i) state_d = cbq_pkg::ST_IDLE;
      default:              state_d = cbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    term_d  = (state_q == cbq_pkg::ST_MAC) ? term_q + 1'b1 : cbq_pkg::TERM_B0;
    stage_d = stage_q;
    if (state_q == cbq_pkg::ST_IDLE) begin
      stage_d = '0;
    end else if (state_q == cbq_pkg::ST_WRITE) begin
      stage_d = last_stage ? '0 : stage_q + 1'b1;
    end
  end

  always_comb begin
    in_ready_o      = 1'b0;
    ctrl_o          = '0;
    ctrl_o.acc_op   = cbq_pkg::ACC_HOLD;
    ctrl_o.op_sel   = cbq_pkg::OPS_TERM;
    ctrl_o.term     = term_q;
    unique case (state_q)
      cbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      cbq_pkg::ST_PRE_MUL: begin
        ctrl_o.op_sel = cbq_pkg::OPS_PRE;
        ctrl_o.mul_en = 1'b1;
      end
      cbq_pkg::ST_PRE_ACC, cbq_pkg::ST_VOL_ACC: begin
        ctrl_o.acc_op   = cbq_pkg::ACC_LOAD;
        ctrl_o.gain_sel = 1'b1;
      end
      cbq_pkg::ST_READ: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.x_load = 1'b1;
      end
      cbq_pkg::ST_MAC: begin
        ctrl_o.mul_en = 1'b1;
        // the accumulator trails the multiplier by one product
        case (term_q) inside
          cbq_pkg::TERM_B1:                   ctrl_o.acc_op = cbq_pkg::ACC_LOAD;
          cbq_pkg::TERM_B2, cbq_pkg::TERM_A1: ctrl_o.acc_op = cbq_pkg::ACC_ADD;
          cbq_pkg::TERM_A2:                   ctrl_o.acc_op = cbq_pkg::ACC_SUB;
          default:                            ctrl_o.acc_op = cbq_pkg::ACC_HOLD;
        endcase
      end
      cbq_pkg::ST_MAC_LAST: begin
        ctrl_o.acc_op = cbq_pkg::ACC_SUB;
      end
      cbq_pkg::ST_WRITE: begin
        ctrl_o.wr_en = 1'b1;
      end
      cbq_pkg::ST_VOL_MUL: begin
        ctrl_o.op_sel = cbq_pkg::OPS_VOL;
        ctrl_o.mul_en = 1'b1;
      end
      cbq_pkg::ST_DONE: begin
        ctrl_o.out_load = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbq_pkg::ST_IDLE;
      term_q  <= cbq_pkg::TERM_B0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// File: bench/cbq_filter_checker.sv
module cbq_filter_checker #(
  parameter int FRAC_BITS    = cbq_pkg::FRAC_BITS_DEF,
  parameter int NUM_STAGES   = cbq_pkg::NUM_STAGES_DEF,
  parameter int NUM_CHANNELS = cbq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = cbq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbq_in_if                             in_mon_i,
  cbq_out_if                            out_mon_i,
  input  logic                          cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cbq_pkg::DATA_W-1:0]    cfg_wdata_i,
  output int                            err_cnt_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbq_pkg::*;

  localparam int MAX_REPORTS = 10;

  // shadow copy of the register file
  logic [DATA_W-1:0]     b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [PRE_GAIN_W-1:0] pre_gain_q;
  logic [VOLUME_W-1:0]   volume_q;

  // per channel and stage filter memory
  row_t hist_q [NUM_CHANNELS][NUM_STAGES];

  logic [DATA_W-1:0] filtered_q [$];
  logic [DATA_W-1:0] want;
  int                mism_cnt;

  assign err_cnt_o = mism_cnt;

  // v times unsigned gain, wrapped to 32 bits, then arithmetic shift by 8
  function automatic logic [DATA_W-1:0] scale_gain(logic [DATA_W-1:0] v,
                                                   logic [DATA_W-1:0] g);
    longint                   prod;
    logic signed [DATA_W-1:0] wrapped;
    prod    = longint'($signed(v)) * longint'(g);
    wrapped = prod[DATA_W-1:0];
    return wrapped >>> GAIN_SHIFT;
  endfunction

  // full signed product, arithmetic shift by the fraction width, truncated
  function automatic logic [DATA_W-1:0] coef_term(logic [DATA_W-1:0] c,
                                                  logic [DATA_W-1:0] v);
    longint prod;
    prod = longint'($signed(c)) * longint'($signed(v));
    prod = prod >>> FRAC_BITS;
    return prod[DATA_W-1:0];
  endfunction

  // one sample through pre-gain, the biquad cascade and volume; updates memory
  function automatic logic [DATA_W-1:0] run_filter(logic [SAMPLE_BITS-1:0] raw,
                                                   logic ch_bit);
    logic signed [SAMPLE_BITS-1:0] s;
    logic [DATA_W-1:0]             x;
    logic [DATA_W-1:0]             acc;
    int                            ch;
    s  = raw;
    x  = s;
    ch = int'(ch_bit);
    if (ch >= NUM_CHANNELS) ch = NUM_CHANNELS - 1;
    x = scale_gain(x, DATA_W'(pre_gain_q));
    for (int st = 0; st < NUM_STAGES; st++) begin
      acc = coef_term(b0_q, x)
          + coef_term(b1_q, hist_q[ch][st].x1)
          + coef_term(b2_q, hist_q[ch][st].x2)
          - coef_term(a1_q, hist_q[ch][st].y1)
          - coef_term(a2_q, hist_q[ch][st].y2);
      hist_q[ch][st].x2 = hist_q[ch][st].x1;
      hist_q[ch][st].x1 = x;
      hist_q[ch][st].y2 = hist_q[ch][st].y1;
      hist_q[ch][st].y1 = acc;
      x = acc;
    end
    return scale_gain(x, DATA_W'(volume_q));
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] got_v);
    if (mism_cnt < MAX_REPORTS)
      $display("%0t: %s: expected %h, got %h", $time, what, exp_v, got_v);
    mism_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q       = '0;
      b1_q       = '0;
      b2_q       = '0;
      a1_q       = '0;
      a2_q       = '0;
      pre_gain_q = PRE_GAIN_RST;
      volume_q   = VOLUME_RST;
      for (int c = 0; c < NUM_CHANNELS; c++)
        for (int st = 0; st < NUM_STAGES; st++)
          hist_q[c][st] = '0;
      filtered_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COEF_B0:  b0_q = cfg_wdata_i;
          REG_COEF_B1:  b1_q = cfg_wdata_i;
          REG_COEF_B2:  b2_q = cfg_wdata_i;
          REG_COEF_A1:  a1_q = cfg_wdata_i;
          REG_COEF_A2:  a2_q = cfg_wdata_i;
          REG_PRE_GAIN: pre_gain_q = cfg_wdata_i[PRE_GAIN_W-1:0];
          REG_VOLUME:   volume_q = cfg_wdata_i[VOLUME_W-1:0];
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (filtered_q.size() == 0) begin
          note_mismatch("sample_out with no item pending", 'x, out_mon_i.sample_out);
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_mon_i.sample_out)
            note_mismatch("sample_out", want, out_mon_i.sample_out);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        filtered_q.push_back(run_filter(in_mon_i.sample_in, in_mon_i.channel));
      pending_o <= filtered_q.size();
    end
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbq_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  // idle tail after the final drain: the core's latency plus some margin
  localparam int TAIL_CYCLES = 5 + 8 * NUM_STAGES_DEF + 20;
  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 108;
  localparam int MAX_BURST   = 18;
  // index past the register map, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  int err_cnt;
  int exp_pending;
  int n_sent;
  int n_settings;
  int quiet_cycles;
  int ready_stall_left;

  // idling control shared by the sample driver and the result sink
  bit idle_en;
  int idle_pct;

  cbq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_bus ();
  cbq_out_if out_bus ();

  cascaded_biquad_stereo_filter_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // predicts every filtered sample and compares it with what comes out
  cbq_filter_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon_i   (in_bus),
    .out_mon_i  (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .err_cnt_o  (err_cnt),
    .pending_o  (exp_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result sink: ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (!idle_en) begin
      ready_stall_left = 0;
      out_bus.ready <= 1'b1;
    end else if (ready_stall_left > 0) begin
      ready_stall_left--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      ready_stall_left = $urandom_range(0, MAX_BURST - 1);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // watchdog: any item, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hand one sample to the block; valid stays high afterwards unless a gap follows
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic ch);
    if (idle_en && $urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= s;
    in_bus.channel   <= ch;
    do @(posedge clk); while (!in_bus.ready);
    n_sent++;
  endtask

  // stop sending and wait until every predicted sample has come out
  task automatic drain_filter();
    in_bus.valid <= 1'b0;
    // let the pending count catch up first so an item taken at this edge is already counted
    @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // full register set, only once the filter has gone quiet
  task automatic load_filter(input logic [DATA_W-1:0] b0, input logic [DATA_W-1:0] b1,
                             input logic [DATA_W-1:0] b2, input logic [DATA_W-1:0] a1,
                             input logic [DATA_W-1:0] a2, input logic [PRE_GAIN_W-1:0] pg,
                             input logic [VOLUME_W-1:0] vol);
    drain_filter();
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    // junk in the unused upper bits of the gain registers must not matter
    write_reg(REG_PRE_GAIN, {(DATA_W - PRE_GAIN_W)'($urandom()), pg});
    write_reg(REG_VOLUME, {(DATA_W - VOLUME_W)'($urandom()), vol});
    write_reg(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return '0;
      4:       return DATA_W'(1) << FRAC_BITS_DEF;
      // small values keep the feedback loop well behaved most of the time
      default: return DATA_W'(int'($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 31)) - 16);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [PRE_GAIN_W-1:0] pick_pre_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return PRE_GAIN_W'(256);
      default: return PRE_GAIN_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    // every input known from time zero, reset held low before release
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;
    in_bus.channel   <= 1'b0;
    idle_en          = 1'b0;
    idle_pct         = 0;
    n_sent           = 0;
    n_settings       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero coefficients and zero pre-gain give silence on both channels
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b0);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b1);

    // plain pass-through: unity b0, unity pre-gain, extremes of the sample field
    load_filter(DATA_W'(1) << FRAC_BITS_DEF, '0, '0, '0, '0, PRE_GAIN_W'(256), '1);
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b0);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b1);
    push_sample('0, 1'b0);
    push_sample('1, 1'b1);
    push_sample(SAMPLE_BITS'(1), 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b1);

    // extreme coefficients and full pre-gain; volume product wraps past 32 bits
    load_filter(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                '1, '1);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b0);
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b0);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b1);
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b1);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b0);
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b1);

    // opposite extremes with both gains at zero; histories keep their large values
    load_filter(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                '0, '0);
    push_sample({1'b0, {(SAMPLE_BITS - 1){1'b1}}}, 1'b0);
    push_sample({1'b1, {(SAMPLE_BITS - 1){1'b0}}}, 1'b1);
    push_sample('1, 1'b0);

    // random phases, each with its own register set and idling mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // a couple of stretches without gaps, and none at all near the end
      idle_en  = (ph < NUM_PHASES - 3) && (ph % 3 != 2);
      idle_pct = $urandom_range(10, 60);
      load_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                  pick_pre_gain(), VOLUME_W'($urandom_range(0, 255)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender holds off now and then until the filter has emptied
        if ((ph == 4 && k == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
          drain_filter();
        push_sample(pick_sample(), 1'($urandom_range(0, 1)));
      end
    end

    drain_filter();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples over %0d register settings, both channels, gaps on both sides",
             n_sent, n_settings);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: cascaded_biquad_stereo_filter_core.f
+incdir+rtl/core
rtl/core/cbq_pkg.sv
rtl/core/cbq_in_if.sv
rtl/core/cbq_out_if.sv
rtl/core/cbq_mac.sv
rtl/core/cbq_hist_mem.sv
rtl/core/cbq_seq.sv
rtl/core/cascaded_biquad_stereo_filter_core.sv
bench/cbq_filter_checker.sv
bench/tb.sv
